/* rtl/dqvs_pkg.sv */
// Shared widths, operation codes and status codes for the value-search deque.
package dqvs_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int KIND_W           = 3;
   localparam int STATUS_W         = 2;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [VALUE_W-1:0]  value_type;

   localparam kind_type KIND_PUSH_FRONT = 3'd0;
   localparam kind_type KIND_PUSH_BACK  = 3'd1;
   localparam kind_type KIND_POP_FRONT  = 3'd2;
   localparam kind_type KIND_POP_BACK   = 3'd3;
   localparam kind_type KIND_CONTAINS   = 3'd4;
   localparam kind_type KIND_REMOVE     = 3'd5;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_EMPTY     = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_NOT_FOUND = 2'd3;

endpackage

/* rtl/dqvs_if.sv */
// Valid/ready channel interfaces for the request and response sides of the deque.
interface dqvs_req_if;
   logic                     valid;
   logic                     ready;
   dqvs_pkg::kind_type       kind;
   logic signed [dqvs_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dqvs_rsp_if #(
   parameter int OCC_W = $clog2(dqvs_pkg::DEFAULT_CAPACITY + 1)
);
   logic                                valid;
   logic                                ready;
   dqvs_pkg::status_type                status;
   logic                                found;
   logic signed [dqvs_pkg::VALUE_W-1:0] front_value;
   logic signed [dqvs_pkg::VALUE_W-1:0] back_value;
   logic [OCC_W-1:0]                    occupancy;
   logic                                is_empty;

   modport source (output valid, output status, output found, output front_value,
                   output back_value, output occupancy, output is_empty, input ready);
   modport sink   (input valid, input status, input found, input front_value,
                   input back_value, input occupancy, input is_empty, output ready);
endinterface

/* rtl/dqvs_store.sv */
// Entry memory of the deque: one write port, one read port with registered data.
module dqvs_store #(
   parameter int DEPTH = dqvs_pkg::DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  dqvs_pkg::value_type        wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output dqvs_pkg::value_type        rd_data
);

   dqvs_pkg::value_type entries_ff [DEPTH];
   dqvs_pkg::value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dqvs_unit.sv */
// Shared slot unit: circular address of head plus offset, and a 32-bit equality compare.
module dqvs_unit #(
   parameter int CAPACITY = dqvs_pkg::DEFAULT_CAPACITY
) (
   input  logic [$clog2(CAPACITY)-1:0] base,
   input  logic [$clog2(CAPACITY)-1:0] offset,
   output logic [$clog2(CAPACITY)-1:0] slot,
   input  dqvs_pkg::value_type         lhs,
   input  dqvs_pkg::value_type         rhs,
   output logic                        equal
);

   localparam int             IDX_W   = $clog2(CAPACITY);
   localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

   logic [IDX_W:0] sum;
   logic [IDX_W:0] wrapped;

   // Both operands are below the capacity, so one subtract folds the sum back.
   assign sum     = {1'b0, base} + {1'b0, offset};
   assign wrapped = sum - CAP_EXT;
   assign slot    = (sum >= CAP_EXT) ? wrapped[IDX_W-1:0] : sum[IDX_W-1:0];
   assign equal   = (lhs == rhs);

endmodule

/* rtl/deque_with_value_search.sv */
// Top level of the bounded double-ended queue with value search and remove.
//
//   Channel  Direction  Transfer when        Payload
//   req_ch   in         valid && ready       kind, value
//   rsp_ch   out        valid && ready       status, found, front_value, back_value,
//                                            occupancy, is_empty
//
// Pushes and pops update the store in ST_EXEC, then read the front and back entries
// through the single read port in ST_FETCH0 and ST_FETCH1; ST_FETCH2 loads the result.
// The next request can be taken in the same cycle as the result appears.
// Contains and remove are bounded by the scan that reads one entry per cycle through
// that port; remove moves the tail down one entry per cycle right behind the scan, so
// it ends no later than a contains over the same count.
// Reset (synchronous) empties the queue at once; the entry memory itself is never cleared.
// A stalled response waits in the output register while the next request is taken; a
// second result then waits for it.
module deque_with_value_search #(
   parameter int CAPACITY = dqvs_pkg::DEFAULT_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   dqvs_req_if.sink   req_ch,
   dqvs_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_FETCH0 = 3'd4;
   localparam logic [2:0] ST_FETCH1 = 3'd5;
   localparam logic [2:0] ST_FETCH2 = 3'd6;

   // Control state.
   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_pos_ff, rd_pos_in;
   logic                  pend_ff, pend_in;
   logic                  out_valid_ff, out_valid_in;

   // Working payload.
   dqvs_pkg::kind_type    kind_ff, kind_in;
   dqvs_pkg::value_type   value_ff, value_in;
   dqvs_pkg::status_type  status_ff, status_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]      wa_ff, wa_in;
   dqvs_pkg::value_type   front_ff, front_in;

   // Output register.
   dqvs_pkg::status_type  out_status_ff, out_status_in;
   logic                  out_found_ff, out_found_in;
   dqvs_pkg::value_type   out_front_ff, out_front_in;
   dqvs_pkg::value_type   out_back_ff, out_back_in;
   logic [CNT_W-1:0]      out_count_ff, out_count_in;

   logic                  req_fire;
   logic                  load_out;
   logic [CNT_W-1:0]      count_m1;
   logic [IDX_W-1:0]      unit_off;
   logic [IDX_W-1:0]      unit_slot;
   logic                  unit_eq;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   dqvs_pkg::value_type   mem_wd;
   logic                  mem_re;
   dqvs_pkg::value_type   mem_rdata;

   dqvs_unit #(
      .CAPACITY (CAPACITY)
   ) u_unit (
      .base   (head_ff),
      .offset (unit_off),
      .slot   (unit_slot),
      .lhs    (mem_rdata),
      .rhs    (value_ff),
      .equal  (unit_eq)
   );

   dqvs_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (unit_slot),
      .rd_data (mem_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign count_m1     = count_ff - CNT_ONE;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rd_pos_in    = rd_pos_ff;
      pend_in      = pend_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      pend_addr_in = pend_addr_ff;
      wa_in        = wa_ff;
      front_in     = front_ff;
      load_out     = 1'b0;
      unit_off     = '0;
      mem_we       = 1'b0;
      mem_wa       = unit_slot;
      mem_wd       = value_ff;
      mem_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = req_ch.kind;
               value_in  = req_ch.value;
               status_in = dqvs_pkg::STATUS_OK;
               found_in  = 1'b0;
               rd_pos_in = '0;
               pend_in   = 1'b0;
               if (req_ch.kind == dqvs_pkg::KIND_CONTAINS ||
                   req_ch.kind == dqvs_pkg::KIND_REMOVE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            // Push and pop update the head, the count and at most one entry.
            unique case (kind_ff)
               dqvs_pkg::KIND_PUSH_FRONT: begin
                  unit_off = IDX_LAST;
                  if (count_ff == CAP_CNT) begin
                     status_in = dqvs_pkg::STATUS_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     head_in  = unit_slot;
                     count_in = count_ff + CNT_ONE;
                  end
               end
               dqvs_pkg::KIND_PUSH_BACK: begin
                  unit_off = count_ff[IDX_W-1:0];
                  if (count_ff == CAP_CNT) begin
                     status_in = dqvs_pkg::STATUS_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_ONE;
                  end
               end
               dqvs_pkg::KIND_POP_FRONT: begin
                  unit_off = IDX_ONE;
                  if (count_ff == '0) begin
                     status_in = dqvs_pkg::STATUS_EMPTY;
                  end else begin
                     head_in  = unit_slot;
                     count_in = count_m1;
                  end
               end
               dqvs_pkg::KIND_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = dqvs_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_m1;
                  end
               end
               default: begin
                  // Unused codes leave the queue as it is.
               end
            endcase
            state_in = ST_FETCH0;
         end

         ST_SCAN, ST_SHIFT: begin
            // One read is issued per cycle; the data of the previous read is
            // compared (scan) or written one entry toward the front (shift).
            unit_off = rd_pos_ff[IDX_W-1:0];
            if (rd_pos_ff < count_ff) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = unit_slot;
               rd_pos_in    = rd_pos_ff + CNT_ONE;
            end else begin
               pend_in = 1'b0;
            end

            if (state_ff == ST_SCAN) begin
               if (pend_ff && unit_eq) begin
                  found_in = 1'b1;
                  if (kind_ff == dqvs_pkg::KIND_REMOVE) begin
                     // The read issued this cycle is the entry just behind the
                     // match, so the shift carries on the same pipeline.
                     wa_in    = pend_addr_ff;
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_FETCH0;
                  end
               end else if (!pend_ff && rd_pos_ff >= count_ff) begin
                  status_in = dqvs_pkg::STATUS_NOT_FOUND;
                  state_in  = ST_FETCH0;
               end
            end else begin
               if (pend_ff) begin
                  mem_we = 1'b1;
                  mem_wa = wa_ff;
                  mem_wd = mem_rdata;
                  wa_in  = pend_addr_ff;
               end
               if (!pend_ff && rd_pos_ff >= count_ff) begin
                  count_in = count_m1;
                  state_in = ST_FETCH0;
               end
            end
         end

         ST_FETCH0: begin
            unit_off = '0;
            mem_re   = 1'b1;
            state_in = ST_FETCH1;
         end

         ST_FETCH1: begin
            unit_off = count_m1[IDX_W-1:0];
            mem_re   = 1'b1;
            front_in = mem_rdata;
            state_in = ST_FETCH2;
         end

         ST_FETCH2: begin
            // The back entry sits in the read register until the result moves out.
            if (!out_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in  = load_out || (out_valid_ff && !rsp_ch.ready);
      out_status_in = out_status_ff;
      out_found_in  = out_found_ff;
      out_front_in  = out_front_ff;
      out_back_in   = out_back_ff;
      out_count_in  = out_count_ff;
      if (load_out) begin
         out_status_in = status_ff;
         out_found_in  = found_ff;
         out_front_in  = (count_ff == '0) ? '0 : front_ff;
         out_back_in   = (count_ff == '0) ? '0 : mem_rdata;
         out_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_pos_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_pos_ff    <= rd_pos_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      pend_addr_ff  <= pend_addr_in;
      wa_ff         <= wa_in;
      front_ff      <= front_in;
      out_status_ff <= out_status_in;
      out_found_ff  <= out_found_in;
      out_front_ff  <= out_front_in;
      out_back_ff   <= out_back_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.found       = out_found_ff;
   assign rsp_ch.front_value = out_front_ff;
   assign rsp_ch.back_value  = out_back_ff;
   assign rsp_ch.occupancy   = out_count_ff;
   assign rsp_ch.is_empty    = (out_count_ff == '0);

endmodule

/* rtl/dqvs_checker.sv */
// Port-level assertions for the deque and the bind that attaches them to the top level.
module dqvs_checker #(
   parameter int CAPACITY = dqvs_pkg::DEFAULT_CAPACITY
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input dqvs_pkg::status_type             rsp_status,
   input logic                             rsp_found,
   input dqvs_pkg::value_type              rsp_front_value,
   input dqvs_pkg::value_type              rsp_back_value,
   input logic [$clog2(CAPACITY+1)-1:0]    rsp_occupancy,
   input logic                             rsp_is_empty
);

   localparam int                CNT_W   = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);

   // A stalled response stays valid and keeps its status, ends and occupancy.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_front_value) && $stable(rsp_back_value) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty queue reports nonzero ends");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == dqvs_pkg::STATUS_OK)
      else $error("found with a failing status");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= CAP_CNT)
      else $error("occupancy above capacity");

endmodule

bind deque_with_value_search dqvs_checker #(
   .CAPACITY (CAPACITY)
) u_dqvs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_found       (rsp_ch.found),
   .rsp_front_value (rsp_ch.front_value),
   .rsp_back_value  (rsp_ch.back_value),
   .rsp_occupancy   (rsp_ch.occupancy),
   .rsp_is_empty    (rsp_ch.is_empty)
);

/* tb/deque_with_value_search_tb.sv */
// Self-checking testbench for the value-search deque: directed cases, then random traffic.
`timescale 1ns / 1ps

module deque_with_value_search_tb;

   localparam int DEPTH = dqvs_pkg::DEFAULT_CAPACITY;
   localparam int OCC_W = $clog2(DEPTH + 1);

   // Kind codes six and seven are not operations; the block must answer them as no-ops.
   localparam dqvs_pkg::kind_type KIND_UNUSED_6 = 3'd6;
   localparam dqvs_pkg::kind_type KIND_UNUSED_7 = 3'd7;

   localparam dqvs_pkg::value_type VALUE_MIN      = 32'h8000_0000;
   localparam dqvs_pkg::value_type VALUE_MAX      = 32'h7FFF_FFFF;
   localparam dqvs_pkg::value_type VALUE_ALL_ONES = 32'hFFFF_FFFF;

   // Mixes of operations for the random batches. Grow and shrink drive the queue to
   // full and to empty; search leans on contains and remove.
   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_SEARCH, MIX_BALANCED} traffic_mix_type;

   // What the queue should report after one operation.
   typedef struct {
      dqvs_pkg::status_type status;
      logic                 found;
      dqvs_pkg::value_type  front_value;
      dqvs_pkg::value_type  back_value;
      logic [OCC_W-1:0]     occupancy;
      logic                 is_empty;
   } deque_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dqvs_req_if req_bus ();
   dqvs_rsp_if #(.OCC_W(OCC_W)) rsp_bus ();

   deque_with_value_search #(.CAPACITY(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the queue: a circular store, the front position and the number held.
   dqvs_pkg::value_type mirror_entries [DEPTH];
   int                  mirror_head  = 0;
   int                  mirror_count = 0;

   // Views still owed by the block, oldest first.
   deque_view_type queue_snapshots [$];

   // When set, neither side inserts idle cycles.
   bit back_to_back = 1'b0;

   int error_count     = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int full_refusals   = 0;
   int empty_refusals  = 0;
   int search_hits     = 0;
   int search_misses   = 0;

   function automatic int draw_gap();
      return back_to_back ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic int slot_of(int pos);
      return (mirror_head + pos) % DEPTH;
   endfunction

   // Logical position of the first match from the front, or the count when absent.
   function automatic int find_first(dqvs_pkg::value_type value);
      for (int i = 0; i < mirror_count; i++) begin
         if (mirror_entries[slot_of(i)] == value) return i;
      end
      return mirror_count;
   endfunction

   // Applies one operation to the mirror and returns the view the block must report.
   function automatic deque_view_type apply_deque_op(dqvs_pkg::kind_type kind,
                                                     dqvs_pkg::value_type value);
      deque_view_type view;
      int pos;
      view.status = dqvs_pkg::STATUS_OK;
      view.found  = 1'b0;
      case (kind)
         dqvs_pkg::KIND_PUSH_FRONT, dqvs_pkg::KIND_PUSH_BACK: begin
            if (mirror_count >= DEPTH) begin
               view.status = dqvs_pkg::STATUS_FULL;
               full_refusals++;
            end else if (kind == dqvs_pkg::KIND_PUSH_FRONT) begin
               mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
               mirror_entries[mirror_head] = value;
               mirror_count++;
            end else begin
               mirror_entries[slot_of(mirror_count)] = value;
               mirror_count++;
            end
         end
         dqvs_pkg::KIND_POP_FRONT, dqvs_pkg::KIND_POP_BACK: begin
            if (mirror_count == 0) begin
               view.status = dqvs_pkg::STATUS_EMPTY;
               empty_refusals++;
            end else begin
               if (kind == dqvs_pkg::KIND_POP_FRONT) mirror_head = (mirror_head + 1) % DEPTH;
               mirror_count--;
            end
         end
         dqvs_pkg::KIND_CONTAINS, dqvs_pkg::KIND_REMOVE: begin
            pos = find_first(value);
            if (pos < mirror_count) begin
               view.found = 1'b1;
               search_hits++;
               if (kind == dqvs_pkg::KIND_REMOVE) begin
                  // Close the gap by moving the tail one place toward the front.
                  for (int i = pos; i + 1 < mirror_count; i++) begin
                     mirror_entries[slot_of(i)] = mirror_entries[slot_of(i + 1)];
                  end
                  mirror_count--;
               end
            end else begin
               view.status = dqvs_pkg::STATUS_NOT_FOUND;
               search_misses++;
            end
         end
         default: ;
      endcase
      view.front_value = (mirror_count == 0) ? '0 : mirror_entries[slot_of(0)];
      view.back_value  = (mirror_count == 0) ? '0 : mirror_entries[slot_of(mirror_count - 1)];
      view.occupancy   = OCC_W'(mirror_count);
      view.is_empty    = (mirror_count == 0);
      return view;
   endfunction

   // Sends one request. The valid line is left high on return so that a following
   // request with no gap goes out on the very next edge; park_request lowers it.
   // Ready only moves at rising edges, so its level at the falling edge tells whether
   // the next rising edge makes the transfer.
   task automatic issue_op(dqvs_pkg::kind_type kind, dqvs_pkg::value_type value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      queue_snapshots.push_back(apply_deque_op(kind, value));
      requests_sent++;
   endtask

   // Drops valid and waits for a rising edge, so valid is never lowered and raised
   // in the same time step.
   task automatic park_request();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Operand choice: searches mostly target a value that is actually stored, and
   // a small pool of values makes duplicates common so remove must pick the first.
   function automatic dqvs_pkg::value_type pick_operand(dqvs_pkg::kind_type kind);
      if ((kind == dqvs_pkg::KIND_CONTAINS || kind == dqvs_pkg::KIND_REMOVE)
          && mirror_count > 0 && $urandom_range(0, 9) < 6)
         return mirror_entries[slot_of($urandom_range(0, mirror_count - 1))];
      case ($urandom_range(0, 7))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return VALUE_ALL_ONES;
         3:       return '0;
         4, 5:    return dqvs_pkg::value_type'($urandom_range(0, 7));
         default: return $urandom();
      endcase
   endfunction

   function automatic dqvs_pkg::kind_type pick_kind(traffic_mix_type mix);
      int push_pct;
      int pop_pct;
      int roll;
      case (mix)
         MIX_GROW:   begin push_pct = 65; pop_pct = 15; end
         MIX_SHRINK: begin push_pct = 15; pop_pct = 55; end
         MIX_SEARCH: begin push_pct = 30; pop_pct = 15; end
         default:    begin push_pct = 40; pop_pct = 35; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 2) return (roll == 0) ? KIND_UNUSED_6 : KIND_UNUSED_7;
      if (roll < 2 + push_pct)
         return $urandom_range(0, 1) ? dqvs_pkg::KIND_PUSH_BACK : dqvs_pkg::KIND_PUSH_FRONT;
      if (roll < 2 + push_pct + pop_pct)
         return $urandom_range(0, 1) ? dqvs_pkg::KIND_POP_BACK : dqvs_pkg::KIND_POP_FRONT;
      return $urandom_range(0, 1) ? dqvs_pkg::KIND_REMOVE : dqvs_pkg::KIND_CONTAINS;
   endfunction

   task automatic run_mix(traffic_mix_type mix, int count);
      dqvs_pkg::kind_type kind;
      for (int i = 0; i < count; i++) begin
         kind = pick_kind(mix);
         issue_op(kind, pick_operand(kind));
      end
   endtask

   // Both pop refusals and a contains miss on an empty queue, plus an unused kind code. The value on
   // the pops is junk that the block must ignore.
   task automatic test_empty_queue();
      issue_op(dqvs_pkg::KIND_POP_FRONT, 32'h1234_5678);
      issue_op(dqvs_pkg::KIND_POP_BACK, VALUE_ALL_ONES);
      issue_op(dqvs_pkg::KIND_CONTAINS, '0);
      issue_op(KIND_UNUSED_7, VALUE_MIN);
   endtask

   // Fills the queue from both ends with extreme values, repeated so that duplicates
   // exist, and with small index values, then tries one more push at each end.
   task automatic test_fill_and_refuse();
      dqvs_pkg::value_type value;
      for (int i = 0; i < DEPTH; i++) begin
         case (i % 4)
            0:       value = VALUE_MIN;
            1:       value = VALUE_MAX;
            2:       value = VALUE_ALL_ONES;
            default: value = dqvs_pkg::value_type'(i);
         endcase
         issue_op((i % 2 == 1) ? dqvs_pkg::KIND_PUSH_FRONT : dqvs_pkg::KIND_PUSH_BACK, value);
      end
      issue_op(dqvs_pkg::KIND_PUSH_FRONT, 32'h0BAD_F00D);
      issue_op(dqvs_pkg::KIND_PUSH_BACK, 32'h0BAD_F00D);
   endtask

   // Search hit and miss on a full queue, removal of the first of several copies,
   // removal of an absent value, a no-op code, and a pop from each end.
   task automatic test_search_and_remove();
      issue_op(dqvs_pkg::KIND_CONTAINS, VALUE_MAX);
      issue_op(dqvs_pkg::KIND_CONTAINS, 32'h5555_5555);
      issue_op(dqvs_pkg::KIND_REMOVE, VALUE_MIN);
      issue_op(dqvs_pkg::KIND_REMOVE, 32'hAAAA_AAAA);
      issue_op(KIND_UNUSED_6, VALUE_MAX);
      issue_op(dqvs_pkg::KIND_POP_FRONT, '0);
      issue_op(dqvs_pkg::KIND_POP_BACK, VALUE_MIN);
   endtask

   // A stretch with both sides always ready, so transfers run at the block's own pace.
   task automatic test_back_to_back();
      back_to_back = 1'b1;
      run_mix(MIX_BALANCED, 60);
      back_to_back = 1'b0;
   endtask

   // Random batches, each with its own mix. Every sixth batch the sender holds off
   // until the block has answered everything it was given.
   task automatic test_random_mix();
      for (int batch = 0; batch < 24; batch++) begin
         run_mix(traffic_mix_type'($urandom_range(0, 3)), 40);
         if (batch % 6 == 5) begin
            park_request();
            while (queue_snapshots.size() != 0) @(posedge clock);
         end
      end
   endtask

   // Response side: drains results with random stalls and checks each transfer
   // against the oldest view still owed. The outputs are sampled at the falling edge,
   // where they are steady, and the transfer happens at the rising edge that follows.
   initial begin : check_responses
      deque_view_type want;
      int stall;
      while (reset) @(posedge clock);
      stall = draw_gap();
      forever begin
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(negedge clock); while (!rsp_bus.valid);
         if (queue_snapshots.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            want = queue_snapshots.pop_front();
            results_checked++;
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
               error_count++;
            end
            if (rsp_bus.front_value !== want.front_value) begin
               $error("front_value: expected %0d, got %0d",
                      $signed(want.front_value), rsp_bus.front_value);
               error_count++;
            end
            if (rsp_bus.back_value !== want.back_value) begin
               $error("back_value: expected %0d, got %0d",
                      $signed(want.back_value), rsp_bus.back_value);
               error_count++;
            end
            if (rsp_bus.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_bus.occupancy);
               error_count++;
            end
            if (rsp_bus.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_bus.is_empty);
               error_count++;
            end
         end
         @(posedge clock);
         stall = draw_gap();
      end
   end

   // Main sequence: reset, the directed tests, the random traffic, then a quiet tail
   // long enough for a full remove to finish, to catch any stray result.
   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind  = dqvs_pkg::KIND_PUSH_FRONT;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_fill_and_refuse();
      test_search_and_remove();
      test_back_to_back();
      test_random_mix();

      park_request();
      while (queue_snapshots.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses.", requests_sent, results_checked);
      $display("Seen: %0d full and %0d empty refusals, %0d search hits, %0d misses.",
               full_refusals, empty_refusals, search_hits, search_misses);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hung handshake; a correct run needs well under a tenth of this.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* deque_with_value_search.f */
rtl/dqvs_pkg.sv
rtl/dqvs_if.sv
rtl/dqvs_store.sv
rtl/dqvs_unit.sv
rtl/deque_with_value_search.sv
rtl/dqvs_checker.sv
tb/deque_with_value_search_tb.sv
